>>> hdl/qpc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// qpc_pkg
// Shared item types, pipeline depths and constants of the pose composer.
// ============================================================================
package qpc_pkg;

    // Pipeline depths of the datapath units, counted from the input register.
    localparam int PROD_LAT  = 5;
    localparam int SQRT_LAT  = 32;
    localparam int DIV_BITS  = 17;
    localparam int NORM_LAT  = DIV_BITS + 2;
    localparam int CORE_LAT  = PROD_LAT + SQRT_LAT + NORM_LAT;
    localparam int POS_LAT   = 7;
    localparam int POS_DLY   = CORE_LAT - POS_LAT;

    // Squared product lengths at or below this value are not normalized.
    localparam logic [63:0] NORM_MIN_SQ = 64'd72057;

    // One input item: base pose and correction pose.
    typedef struct packed {
        logic signed [31:0] base_pos_x;
        logic signed [31:0] base_pos_y;
        logic signed [31:0] base_pos_z;
        logic        [63:0] base_quat;
        logic signed [31:0] offset_pos_x;
        logic signed [31:0] offset_pos_y;
        logic signed [31:0] offset_pos_z;
        logic        [63:0] offset_quat;
    } t_in_item;

    // One result item: composed pose.
    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] pose_z;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic signed [15:0] rot_w;
    } t_out_item;

    // Magnitude and sign of the four Hamilton product terms.
    typedef struct packed {
        logic [3:0][32:0] mag;
        logic [3:0]       neg;
    } t_qlane;

    // Product terms with their saturated sum of squares.
    typedef struct packed {
        logic [63:0] sum_sq;
        t_qlane      lane;
    } t_quat_mid;

    // Product terms with the integer length and the normalize flag.
    typedef struct packed {
        logic [31:0] len;
        logic        norm;
        t_qlane      lane;
    } t_quat_len;

endpackage

>>> hdl/qpc_pos.sv
`timescale 1ns / 1ps
// ============================================================================
// qpc_pos
// Position path: rotates the offset by the base quaternion, adds base and
// offset, saturates, and delays the result to line up with the rotation path.
// ============================================================================
module qpc_pos import qpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_in_item         i_item,
    output logic [2:0][31:0] o_pose
);

    logic signed [15:0] a [4];
    logic signed [31:0] d [3];
    logic signed [31:0] bp [3];

    logic signed [15:0] r_a1 [4];
    logic signed [15:0] r_a2 [4];
    logic signed [15:0] r_a3 [4];
    logic signed [32:0] r_bd1 [3];
    logic signed [32:0] r_bd2 [3];
    logic signed [32:0] r_bd3 [3];
    logic signed [32:0] r_bd4 [3];
    logic signed [32:0] r_bd5 [3];
    logic signed [32:0] r_bd6 [3];
    logic signed [47:0] r_m [6];
    logic signed [48:0] r_c [3];
    logic signed [35:0] r_t [3];
    logic signed [35:0] n_t [3];
    logic signed [51:0] r_w [3];
    logic signed [51:0] r_x [3];
    logic signed [51:0] r_y [3];
    logic signed [53:0] r_r [3];
    logic signed [39:0] r_rr [3];
    logic signed [39:0] n_rr [3];
    logic signed [40:0] n_sum [3];
    logic [2:0][31:0]   n_pose;
    logic [2:0][31:0]   r_dly [POS_DLY + 1];

    // Unpack the fields.
    assign a[0]  = $signed(i_item.base_quat[15:0]);
    assign a[1]  = $signed(i_item.base_quat[31:16]);
    assign a[2]  = $signed(i_item.base_quat[47:32]);
    assign a[3]  = $signed(i_item.base_quat[63:48]);
    assign d[0]  = i_item.offset_pos_x;
    assign d[1]  = i_item.offset_pos_y;
    assign d[2]  = i_item.offset_pos_z;
    assign bp[0] = i_item.base_pos_x;
    assign bp[1] = i_item.base_pos_y;
    assign bp[2] = i_item.base_pos_z;

    // Rounding of the two scale reductions: half away from zero in one add.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i]  = 36'((r_c[i] + (r_c[i][48] ? 49'sd4095 : 49'sd4096)) >>> 13);
            n_rr[i] = 40'((r_r[i] + (r_r[i][53] ? 54'sd8191 : 54'sd8192)) >>> 14);
        end
    end

    // Final sum and saturation to 32 bits.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = 41'(r_bd6[i]) + 41'(r_rr[i]);
            if (n_sum[i] > 41'sd2147483647) begin
                n_pose[i] = 32'h7FFF_FFFF;
            end else if (n_sum[i] < -41'sd2147483648) begin
                n_pose[i] = 32'h8000_0000;
            end else begin
                n_pose[i] = n_sum[i][31:0];
            end
        end
    end

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Cross product qv x d.
            r_a1   <= a;
            for (int i = 0; i < 3; i++) begin
                r_bd1[i] <= 33'(bp[i]) + 33'(d[i]);
            end
            r_m[0] <= a[1] * d[2];
            r_m[1] <= a[2] * d[1];
            r_m[2] <= a[2] * d[0];
            r_m[3] <= a[0] * d[2];
            r_m[4] <= a[0] * d[1];
            r_m[5] <= a[1] * d[0];
            r_a2   <= r_a1;
            r_bd2  <= r_bd1;
            r_c[0] <= 49'(r_m[0]) - 49'(r_m[1]);
            r_c[1] <= 49'(r_m[2]) - 49'(r_m[3]);
            r_c[2] <= 49'(r_m[4]) - 49'(r_m[5]);
            // Scale to t = 2c.
            r_a3   <= r_a2;
            r_bd3  <= r_bd2;
            r_t    <= n_t;
            // w*t + qv x t.
            r_bd4  <= r_bd3;
            for (int i = 0; i < 3; i++) begin
                r_w[i] <= r_a3[3] * r_t[i];
            end
            r_x[0] <= r_a3[1] * r_t[2];
            r_y[0] <= r_a3[2] * r_t[1];
            r_x[1] <= r_a3[2] * r_t[0];
            r_y[1] <= r_a3[0] * r_t[2];
            r_x[2] <= r_a3[0] * r_t[1];
            r_y[2] <= r_a3[1] * r_t[0];
            r_bd5  <= r_bd4;
            for (int i = 0; i < 3; i++) begin
                r_r[i] <= 54'(r_w[i]) + 54'(r_x[i]) - 54'(r_y[i]);
            end
            r_bd6  <= r_bd5;
            r_rr   <= n_rr;
            // Align with the rotation path.
            r_dly[0] <= n_pose;
            for (int k = 1; k <= POS_DLY; k++) begin
                r_dly[k] <= r_dly[k - 1];
            end
        end
    end

    assign o_pose = r_dly[POS_DLY];

endmodule

>>> hdl/qpc_qprod.sv
`timescale 1ns / 1ps
// ============================================================================
// qpc_qprod
// Hamilton product of the two quaternions and its saturated sum of squares.
// ============================================================================
module qpc_qprod import qpc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_in_item  i_item,
    output t_quat_mid o_mid
);

    logic signed [15:0] a [4];
    logic signed [15:0] b [4];
    logic signed [31:0] r_pm [4][4];
    logic signed [33:0] r_p [4];
    logic [3:0][32:0]   r_mag3, r_mag4;
    logic [3:0]         r_neg3, r_neg4;
    logic [63:0]        r_sq [4];
    logic [65:0]        n_sum;
    t_quat_mid          r_mid;

    // Unpack the quaternion halves.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            a[i] = $signed(i_item.base_quat[16 * i +: 16]);
            b[i] = $signed(i_item.offset_quat[16 * i +: 16]);
        end
    end

    assign n_sum = 66'(r_sq[0]) + 66'(r_sq[1]) + 66'(r_sq[2]) + 66'(r_sq[3]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Partial products.
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_pm[i][j] <= a[i] * b[j];
                end
            end
            // Product terms, index 3 is w.
            r_p[0] <= 34'(r_pm[3][0]) + 34'(r_pm[0][3]) + 34'(r_pm[1][2]) - 34'(r_pm[2][1]);
            r_p[1] <= 34'(r_pm[3][1]) - 34'(r_pm[0][2]) + 34'(r_pm[1][3]) + 34'(r_pm[2][0]);
            r_p[2] <= 34'(r_pm[3][2]) + 34'(r_pm[0][1]) - 34'(r_pm[1][0]) + 34'(r_pm[2][3]);
            r_p[3] <= 34'(r_pm[3][3]) - 34'(r_pm[0][0]) - 34'(r_pm[1][1]) - 34'(r_pm[2][2]);
            // Sign and magnitude.
            for (int i = 0; i < 4; i++) begin
                r_neg3[i] <= r_p[i][33];
                r_mag3[i] <= r_p[i][33] ? 33'(-r_p[i]) : 33'(r_p[i]);
            end
            // Squares; a magnitude of 2^32 saturates.
            r_mag4 <= r_mag3;
            r_neg4 <= r_neg3;
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= r_mag3[i][32] ? '1
                         : 64'(r_mag3[i][31:0]) * 64'(r_mag3[i][31:0]);
            end
            // Saturating sum.
            r_mid.sum_sq   <= (n_sum[65:64] != 2'b00) ? '1 : n_sum[63:0];
            r_mid.lane.mag <= r_mag4;
            r_mid.lane.neg <= r_neg4;
        end
    end

    assign o_mid = r_mid;

endmodule

>>> hdl/qpc_sqrt.sv
`timescale 1ns / 1ps
// ============================================================================
// qpc_sqrt
// Integer square root of the sum of squares, one result bit per stage.
// ============================================================================
module qpc_sqrt import qpc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_quat_mid i_mid,
    output t_quat_len o_len
);

    logic [63:0] r_v [SQRT_LAT];
    logic [63:0] r_r [SQRT_LAT];
    t_qlane      r_lane [SQRT_LAT];
    logic        r_norm [SQRT_LAT];

    for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] v_in, r_in, n_v, n_r;
        logic [64:0] trial;
        t_qlane      lane_in;
        logic        norm_in;

        if (k == 0) begin : g_first
            assign v_in    = i_mid.sum_sq;
            assign r_in    = '0;
            assign lane_in = i_mid.lane;
            assign norm_in = i_mid.sum_sq > NORM_MIN_SQ;
        end else begin : g_next
            assign v_in    = r_v[k - 1];
            assign r_in    = r_r[k - 1];
            assign lane_in = r_lane[k - 1];
            assign norm_in = r_norm[k - 1];
        end

        // One trial subtraction of the bitwise root.
        assign trial = {1'b0, r_in} + {1'b0, BIT};
        always_comb begin
            if ({1'b0, v_in} >= trial) begin
                n_v = v_in - trial[63:0];
                n_r = (r_in >> 1) + BIT;
            end else begin
                n_v = v_in;
                n_r = r_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k]    <= n_v;
                r_r[k]    <= n_r;
                r_lane[k] <= lane_in;
                r_norm[k] <= norm_in;
            end
        end
    end

    assign o_len.len  = r_r[SQRT_LAT - 1][31:0];
    assign o_len.norm = r_norm[SQRT_LAT - 1];
    assign o_len.lane = r_lane[SQRT_LAT - 1];

endmodule

>>> hdl/qpc_norm.sv
`timescale 1ns / 1ps
// ============================================================================
// qpc_norm
// Divides each product term by the length with restoring division, or
// rounds it to nearest in Q2.14 when the product is too short, then saturates.
// ============================================================================
module qpc_norm import qpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_quat_len        i_len,
    output logic [3:0][15:0] o_rot
);

    typedef struct packed {
        logic [31:0]            len;
        logic                   norm;
        logic [3:0]             neg;
        logic [3:0][15:0]       fb;
        logic [3:0][47:0]       rem;
        logic [3:0][DIV_BITS-1:0] quo;
    } t_dstage;

    t_dstage          r_st [DIV_BITS + 1];
    t_dstage          n_st0;
    logic [19:0]      fb_m [4];
    logic [3:0][15:0] n_rot;
    logic [3:0][15:0] r_rot;

    // Setup: rounded dividend and the unnormalized fallback value.
    always_comb begin
        n_st0      = '0;
        n_st0.len  = i_len.len;
        n_st0.norm = i_len.norm;
        n_st0.neg  = i_len.lane.neg;
        for (int j = 0; j < 4; j++) begin
            n_st0.rem[j] = {1'b0, i_len.lane.mag[j], 14'b0} + 48'(i_len.len[31:1]);
            fb_m[j]      = 20'((34'(i_len.lane.mag[j]) + 34'd8192) >> 14);
            if (i_len.lane.neg[j]) begin
                n_st0.fb[j] = (fb_m[j] > 20'd32768) ? 16'h8000 : 16'(-fb_m[j]);
            end else begin
                n_st0.fb[j] = (fb_m[j] > 20'd32767) ? 16'h7FFF : fb_m[j][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
        localparam int SH = DIV_BITS - k;
        logic [47:0] trial;
        t_dstage     n_st;

        assign trial = 48'(r_st[k - 1].len) << SH;
        always_comb begin
            n_st = r_st[k - 1];
            for (int j = 0; j < 4; j++) begin
                if (r_st[k - 1].rem[j] >= trial) begin
                    n_st.rem[j]     = r_st[k - 1].rem[j] - trial;
                    n_st.quo[j][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    // Sign and saturate the quotient, or take the fallback.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (!r_st[DIV_BITS].norm) begin
                n_rot[j] = r_st[DIV_BITS].fb[j];
            end else if (r_st[DIV_BITS].neg[j]) begin
                n_rot[j] = (r_st[DIV_BITS].quo[j] > 17'd32768) ? 16'h8000
                         : 16'(-r_st[DIV_BITS].quo[j]);
            end else begin
                n_rot[j] = (r_st[DIV_BITS].quo[j] > 17'd32767) ? 16'h7FFF
                         : r_st[DIV_BITS].quo[j][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;

endmodule

>>> hdl/quaternion_pose_composer.sv
`timescale 1ns / 1ps
// ============================================================================
// quaternion_pose_composer
// Composes a base pose with a correction pose: rotated offset position and
// normalized quaternion product, both rounded and saturated.
// ============================================================================
// Usage:
//   Input channel i_valid / o_stall / i_item carries one base and correction
//   pose pair per item; output channel o_valid / i_stall / o_item carries
//   the composed pose. An item is taken at a clock edge with valid high and
//   stall low.
//   Throughput is one item per cycle while o_stall is low. From acceptance
//   to o_valid an item passes one input register, a 56-stage datapath
//   set by the 32-stage bitwise square root and the 17-stage restoring
//   divider, and the output register.
//   Synchronous active-low reset clears all valid bits; no item is invented
//   across it, but items in flight are lost. A stalled output holds its
//   item; the next finished item waits in a skid register, and only when
//   that is full does the whole pipeline hold and o_stall rise.
// ============================================================================
module quaternion_pose_composer import qpc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic [CORE_LAT:0] r_vld;
    logic              r_ov, r_sv;
    t_in_item          r_in;
    t_out_item         r_out, r_skid, res;
    logic              en, arrive, take;
    logic [2:0][31:0]  pose;
    logic [3:0][15:0]  rot;
    t_quat_mid         mid;
    t_quat_len         qlen;

    assign en     = !r_sv;
    assign arrive = en && r_vld[CORE_LAT];
    assign take   = r_ov && !i_stall;

    // Datapath units.
    qpc_pos u_pos (
        .i_clk (i_clk),
        .i_en  (en),
        .i_item(r_in),
        .o_pose(pose)
    );

    qpc_qprod u_qprod (
        .i_clk (i_clk),
        .i_en  (en),
        .i_item(r_in),
        .o_mid (mid)
    );

    qpc_sqrt u_sqrt (
        .i_clk(i_clk),
        .i_en (en),
        .i_mid(mid),
        .o_len(qlen)
    );

    qpc_norm u_norm (
        .i_clk(i_clk),
        .i_en (en),
        .i_len(qlen),
        .o_rot(rot)
    );

    // Assemble the finished item.
    always_comb begin
        res.pose_x = pose[0];
        res.pose_y = pose[1];
        res.pose_z = pose[2];
        res.rot_x  = rot[0];
        res.rot_y  = rot[1];
        res.rot_z  = rot[2];
        res.rot_w  = rot[3];
    end

    // Valid chain, output register and skid control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
            r_sv  <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[CORE_LAT-1:0], i_valid};
            end
            if (take) begin
                if (r_sv) begin
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= arrive;
                end
            end else if (arrive) begin
                if (!r_ov) begin
                    r_ov <= 1'b1;
                end else begin
                    r_sv <= 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_item;
        end
        if (take) begin
            if (r_sv) begin
                r_out <= r_skid;
            end else if (arrive) begin
                r_out <= res;
            end
        end else if (arrive) begin
            if (!r_ov) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_stall = r_sv;
    assign o_valid = r_ov;
    assign o_item  = r_out;

endmodule

>>> hdl/qpc_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// qpc_checker
// Port-level checks of the pose composer, bound to the top level.
// ============================================================================
module qpc_checker import qpc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_item  i_item,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_item
);

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled output item changed");

    // Input backpressure only arises behind a waiting result.
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    // Backpressure starts only after the receiver stalled a result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall rose without output stall");

endmodule

bind quaternion_pose_composer qpc_checker u_qpc_checker (.*);
